// ===== rtl/core/link_reconnect_manager_macros.svh =====
// Assertion macros shared by the link reconnect manager state machine and top level.
`ifndef LINK_RECONNECT_MANAGER_MACROS_SVH
`define LINK_RECONNECT_MANAGER_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define LRM_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define LRM_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lrm_pkg.sv =====
// Types, codes and widths shared by the link reconnect manager.
package lrm_pkg;

  localparam int TIME_W  = 32;
  localparam int CNT_W   = 8;
  localparam int LIMIT_W = 8;
  localparam int DELAY_W = 31;
  localparam int SIG_W   = 8;
  localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Item kinds.
  localparam logic [1:0] KIND_TICK       = 2'd0;
  localparam logic [1:0] KIND_CONNECT    = 2'd1;
  localparam logic [1:0] KIND_DISCONNECT = 2'd2;

  // Radio link status codes.
  localparam logic [1:0] LS_OTHER     = 2'd0;
  localparam logic [1:0] LS_CONNECTED = 2'd1;
  localparam logic [1:0] LS_FAILED    = 2'd2;
  localparam logic [1:0] LS_NO_NET    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RETRY_LIMIT    = 2'd0;
  localparam logic [1:0] CFG_RETRY_DELAY    = 2'd1;
  localparam logic [1:0] CFG_ATTEMPT_TMO    = 2'd2;
  localparam logic [1:0] CFG_AUTO_RECONNECT = 2'd3;

  typedef enum logic [1:0] {
    MODE_DISC = 2'd0,
    MODE_CONN = 2'd1,
    MODE_UP   = 2'd2,
    MODE_ERR  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] retry_limit;
    logic [DELAY_W-1:0] retry_delay_ms;
    logic [TIME_W-1:0]  attempt_timeout_ms;
    logic               auto_reconnect;
  } lrm_cfg_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [TIME_W-1:0]       now_ms;
    logic [1:0]              link_status;
    logic signed [SIG_W-1:0] signal_in;
    logic                    credentials_given;
    logic                    name_present;
  } lrm_item_t;

  typedef struct packed {
    mode_t                   link_state;
    logic                    link_up;
    logic [CNT_W-1:0]        retries;
    logic [TIME_W-1:0]       connected_time_ms;
    logic signed [SIG_W-1:0] signal_level;
    logic                    begin_attempt;
    logic                    radio_off;
    logic                    accepted;
  } lrm_result_t;

endpackage

// ===== rtl/core/lrm_if.sv =====
// Valid/ready channel interfaces for input items, results and configuration writes.
interface lrm_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [1:0]                              kind;
  logic [lrm_pkg::TIME_W-1:0]              now_ms;
  logic [1:0]                              link_status;
  logic signed [lrm_pkg::SIG_W-1:0]        signal_in;
  logic                                    credentials_given;
  logic                                    name_present;

  modport source (
    output valid, kind, now_ms, link_status, signal_in, credentials_given, name_present,
    input  ready
  );
  modport sink (
    input  valid, kind, now_ms, link_status, signal_in, credentials_given, name_present,
    output ready
  );
endinterface

interface lrm_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [1:0]                              link_state;
  logic                                    link_up;
  logic [lrm_pkg::CNT_W-1:0]               retries;
  logic [lrm_pkg::TIME_W-1:0]              connected_time_ms;
  logic signed [lrm_pkg::SIG_W-1:0]        signal_level;
  logic                                    begin_attempt;
  logic                                    radio_off;
  logic                                    accepted;

  modport source (
    output valid, link_state, link_up, retries, connected_time_ms, signal_level,
           begin_attempt, radio_off, accepted,
    input  ready
  );
  modport sink (
    input  valid, link_state, link_up, retries, connected_time_ms, signal_level,
           begin_attempt, radio_off, accepted,
    output ready
  );
endinterface

interface lrm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 index;
  logic [lrm_pkg::TIME_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lrm_cfg_regs.sv =====
// Configuration register file written through the configuration channel.
module lrm_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  lrm_cfg_if.sink           cfg_ch,
  output lrm_pkg::lrm_cfg_t cfg
);

  lrm_pkg::lrm_cfg_t cfg_r;
  lrm_pkg::lrm_cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        lrm_pkg::CFG_RETRY_LIMIT: begin
          cfg_nxt.retry_limit = cfg_ch.data[lrm_pkg::LIMIT_W-1:0];
        end
        lrm_pkg::CFG_RETRY_DELAY: begin
          cfg_nxt.retry_delay_ms = cfg_ch.data[lrm_pkg::DELAY_W-1:0];
        end
        lrm_pkg::CFG_ATTEMPT_TMO: begin
          cfg_nxt.attempt_timeout_ms = cfg_ch.data;
        end
        lrm_pkg::CFG_AUTO_RECONNECT: begin
          cfg_nxt.auto_reconnect = cfg_ch.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit        <= lrm_pkg::LIMIT_W'(10);
      cfg_r.retry_delay_ms     <= lrm_pkg::DELAY_W'(5000);
      cfg_r.attempt_timeout_ms <= lrm_pkg::TIME_W'(30000);
      cfg_r.auto_reconnect     <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/core/lrm_fsm.sv =====
// Link state machine: state registers and the single-pass update for one item.
`include "link_reconnect_manager_macros.svh"

module lrm_fsm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd,
  input  lrm_pkg::lrm_item_t   item,
  input  lrm_pkg::lrm_cfg_t    cfg,
  output lrm_pkg::lrm_result_t res
);

  lrm_pkg::mode_t                   mode_r, mode_nxt;
  logic                             up_flag_r, up_flag_nxt;
  logic [lrm_pkg::CNT_W-1:0]        fail_count_r, fail_count_nxt;
  logic [lrm_pkg::TIME_W-1:0]       attempt_time_r, attempt_time_nxt;
  logic [lrm_pkg::TIME_W-1:0]       up_duration_r, up_duration_nxt;
  logic signed [lrm_pkg::SIG_W-1:0] last_signal_r, last_signal_nxt;
  logic                             have_name_r, have_name_nxt;

  logic [lrm_pkg::TIME_W-1:0] since;
  logic [lrm_pkg::CNT_W-1:0]  fail_inc;
  logic                       at_limit;
  logic                       begin_att;
  logic                       roff;
  logic                       acc;

  // Elapsed time since the last attempt wraps with the clock counter.
  assign since    = item.now_ms - attempt_time_r;
  assign fail_inc = (fail_count_r < lrm_pkg::CNT_MAX) ?
                    fail_count_r + lrm_pkg::CNT_W'(1) : fail_count_r;
  assign at_limit = lrm_pkg::CMP_W'(fail_inc) >= lrm_pkg::CMP_W'(cfg.retry_limit);

  always_comb begin
    mode_nxt         = mode_r;
    up_flag_nxt      = up_flag_r;
    fail_count_nxt   = fail_count_r;
    attempt_time_nxt = attempt_time_r;
    up_duration_nxt  = up_duration_r;
    last_signal_nxt  = last_signal_r;
    have_name_nxt    = have_name_r;
    begin_att        = 1'b0;
    roff             = 1'b0;
    acc              = 1'b1;

    unique case (item.kind)
      lrm_pkg::KIND_CONNECT: begin
        if (item.credentials_given) begin
          have_name_nxt    = item.name_present;
          mode_nxt         = lrm_pkg::MODE_CONN;
          fail_count_nxt   = '0;
          attempt_time_nxt = item.now_ms;
          begin_att        = 1'b1;
        end else begin
          acc = 1'b0;
        end
      end
      lrm_pkg::KIND_DISCONNECT: begin
        mode_nxt    = lrm_pkg::MODE_DISC;
        up_flag_nxt = 1'b0;
        roff        = 1'b1;
      end
      lrm_pkg::KIND_TICK: begin
        unique case (mode_r)
          lrm_pkg::MODE_DISC: begin
            if (cfg.auto_reconnect && have_name_r &&
                since > lrm_pkg::TIME_W'(cfg.retry_delay_ms)) begin
              mode_nxt         = lrm_pkg::MODE_CONN;
              attempt_time_nxt = item.now_ms;
              begin_att        = 1'b1;
            end
          end
          lrm_pkg::MODE_CONN: begin
            if (item.link_status == lrm_pkg::LS_CONNECTED) begin
              mode_nxt       = lrm_pkg::MODE_UP;
              up_flag_nxt    = 1'b1;
              fail_count_nxt = '0;
            end else if (item.link_status == lrm_pkg::LS_FAILED ||
                         item.link_status == lrm_pkg::LS_NO_NET) begin
              fail_count_nxt = fail_inc;
              if (at_limit) begin
                mode_nxt    = lrm_pkg::MODE_ERR;
                up_flag_nxt = 1'b0;
              end else begin
                mode_nxt         = lrm_pkg::MODE_DISC;
                attempt_time_nxt = item.now_ms;
              end
            end else if (since > cfg.attempt_timeout_ms) begin
              mode_nxt    = lrm_pkg::MODE_ERR;
              up_flag_nxt = 1'b0;
            end
          end
          lrm_pkg::MODE_UP: begin
            if (item.link_status == lrm_pkg::LS_CONNECTED) begin
              last_signal_nxt = item.signal_in;
              up_duration_nxt = since;
            end else begin
              mode_nxt         = lrm_pkg::MODE_DISC;
              up_flag_nxt      = 1'b0;
              fail_count_nxt   = '0;
              attempt_time_nxt = item.now_ms;
            end
          end
          lrm_pkg::MODE_ERR: begin
            // The error state holds off for twice the retry delay.
            if (since > lrm_pkg::TIME_W'({cfg.retry_delay_ms, 1'b0})) begin
              mode_nxt         = lrm_pkg::MODE_DISC;
              fail_count_nxt   = '0;
              attempt_time_nxt = item.now_ms;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    res.link_state        = mode_nxt;
    res.link_up           = up_flag_nxt;
    res.retries           = fail_count_nxt;
    res.connected_time_ms = up_duration_nxt;
    res.signal_level      = last_signal_nxt;
    res.begin_attempt     = begin_att;
    res.radio_off         = roff;
    res.accepted          = acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= lrm_pkg::MODE_DISC;
      up_flag_r      <= 1'b0;
      fail_count_r   <= '0;
      attempt_time_r <= '0;
      up_duration_r  <= '0;
      last_signal_r  <= '0;
      have_name_r    <= 1'b0;
    end else if (upd) begin
      mode_r         <= mode_nxt;
      up_flag_r      <= up_flag_nxt;
      fail_count_r   <= fail_count_nxt;
      attempt_time_r <= attempt_time_nxt;
      up_duration_r  <= up_duration_nxt;
      last_signal_r  <= last_signal_nxt;
      have_name_r    <= have_name_nxt;
    end
  end

  `LRM_ASSERT_NOW(a_up_has_flag, clk, rst_n, mode_r == lrm_pkg::MODE_UP, up_flag_r,
                  "connected state without the up flag")
  `LRM_ASSERT_NOW(a_err_no_flag, clk, rst_n, mode_r == lrm_pkg::MODE_ERR, !up_flag_r,
                  "error state with the up flag set")
  `LRM_ASSERT_NEXT(a_disc_cmd, clk, rst_n, upd && item.kind == lrm_pkg::KIND_DISCONNECT,
                   mode_r == lrm_pkg::MODE_DISC && !up_flag_r,
                   "disconnect command did not drop the link")

endmodule

// ===== rtl/core/link_reconnect_manager.sv =====
// Link reconnect manager top level: input register, state machine and result register.
// Order: an accepted item is held in the input register; the state update and the result
// register both take effect when it advances, which a stalled output can hold back.
// Throughput: one item per cycle unless the output stalls; one single-pass update per item.
// Synchronous active-low reset returns the link to disconnected with all counts and
// times cleared and the configuration registers at their defaults.
`include "link_reconnect_manager_macros.svh"

module link_reconnect_manager (
  input  logic      clk,
  input  logic      rst_n,
  lrm_in_if.sink    in_ch,
  lrm_out_if.source out_ch,
  lrm_cfg_if.sink   cfg_ch
);

  lrm_pkg::lrm_cfg_t    cfg;
  lrm_pkg::lrm_item_t   in_item;
  lrm_pkg::lrm_item_t   item_r;
  lrm_pkg::lrm_result_t res;
  lrm_pkg::lrm_result_t out_res_r;

  logic item_v_r, item_v_nxt;
  logic out_v_r, out_v_nxt;
  logic in_fire;
  logic adv;

  assign in_item.kind              = in_ch.kind;
  assign in_item.now_ms            = in_ch.now_ms;
  assign in_item.link_status       = in_ch.link_status;
  assign in_item.signal_in         = in_ch.signal_in;
  assign in_item.credentials_given = in_ch.credentials_given;
  assign in_item.name_present      = in_ch.name_present;

  // The held item moves on whenever the result register is free or being emptied.
  assign adv         = item_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !item_v_r || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  lrm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  lrm_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (adv),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_comb begin
    item_v_nxt = item_v_r;
    if (in_fire) begin
      item_v_nxt = 1'b1;
    end else if (adv) begin
      item_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.link_state        = out_res_r.link_state;
  assign out_ch.link_up           = out_res_r.link_up;
  assign out_ch.retries           = out_res_r.retries;
  assign out_ch.connected_time_ms = out_res_r.connected_time_ms;
  assign out_ch.signal_level      = out_res_r.signal_level;
  assign out_ch.begin_attempt     = out_res_r.begin_attempt;
  assign out_ch.radio_off         = out_res_r.radio_off;
  assign out_ch.accepted          = out_res_r.accepted;

  `LRM_ASSERT_NEXT(a_adv_fills_out, clk, rst_n, adv, out_v_r,
                   "updated item did not reach the result register")
  `LRM_ASSERT_NOW(a_begin_conn, clk, rst_n, out_v_r && out_res_r.begin_attempt,
                  out_res_r.link_state == lrm_pkg::MODE_CONN && out_res_r.accepted,
                  "attempt pulse without the connecting state")
  `LRM_ASSERT_NOW(a_off_disc, clk, rst_n, out_v_r && out_res_r.radio_off,
                  out_res_r.link_state == lrm_pkg::MODE_DISC && !out_res_r.link_up &&
                  !out_res_r.begin_attempt,
                  "radio off pulse while the link is not down")

endmodule
